// ===== sv/cramer_3x3_solver_unit_assert.svh =====
// assertion macros shared by the solver checker
`ifndef CRAMER_3X3_SOLVER_UNIT_ASSERT_SVH
`define CRAMER_3X3_SOLVER_UNIT_ASSERT_SVH

// same-cycle implication
`define C3S_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("c3s check failed");

// next-cycle implication
`define C3S_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("c3s check failed");

`endif

// ===== sv/c3s_pkg.sv =====
// shared constants and the sarrus term table for the 3x3 solver
`timescale 1ns / 1ps
package c3s_pkg;
  localparam int CW_DEF = 16;
  localparam int RW_DEF = 32;
  localparam int RF_DEF = 16;
  localparam int QDEPTH = 4;
  localparam int NUM_DETS = 4;
  localparam int NUM_TERMS = 6;
  // column picked from rows 0..2 for each sarrus term; first three add, last three subtract
  localparam logic [1:0] SARRUS_COL [NUM_TERMS][3] = '{
    '{2'd0, 2'd1, 2'd2},
    '{2'd1, 2'd2, 2'd0},
    '{2'd2, 2'd0, 2'd1},
    '{2'd2, 2'd1, 2'd0},
    '{2'd1, 2'd0, 2'd2},
    '{2'd0, 2'd2, 2'd1}
  };
endpackage

// ===== sv/c3s_front.sv =====
// front end: pipelined determinants and sign/magnitude split
`timescale 1ns / 1ps
module c3s_front #(
  parameter int COEF_WIDTH = c3s_pkg::CW_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [COEF_WIDTH-1:0] a [3][3],
  input  logic signed [COEF_WIDTH-1:0] b [3],
  output logic push,
  input  logic full,
  output logic [4*3*COEF_WIDTH+3:0] entry
);
  import c3s_pkg::*;
  localparam int CW = COEF_WIDTH;
  localparam int MW = 3 * CW;
  localparam int DW = MW + 1;

  logic adv;
  logic v1, v2, v3;
  logic signed [CW-1:0]   m [NUM_DETS][3][3];
  logic signed [2*CW-1:0] p1 [NUM_DETS][NUM_TERMS];
  logic signed [CW-1:0]   t1 [NUM_DETS][NUM_TERMS];
  logic signed [MW-1:0]   p2 [NUM_DETS][NUM_TERMS];
  logic signed [DW-1:0]   det [NUM_DETS];
  logic [DW-1:0]          absd [NUM_DETS];

  assign adv = !(v3 && full);
  assign in_stall = !adv;
  assign push = v3 && !full;

  // matrix 0 is a itself, matrix k has column k-1 replaced by b
  always_comb begin
    for (int k = 0; k < NUM_DETS; k++)
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          m[k][r][c] = (k != 0 && c == k - 1) ? b[r] : a[r][c];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_DETS; k++) begin
        for (int t = 0; t < NUM_TERMS; t++) begin
          p1[k][t] <= (2*CW)'(m[k][0][SARRUS_COL[t][0]]) * (2*CW)'(m[k][1][SARRUS_COL[t][1]]);
          t1[k][t] <= m[k][2][SARRUS_COL[t][2]];
          p2[k][t] <= MW'(p1[k][t]) * MW'(t1[k][t]);
        end
        det[k] <= DW'(p2[k][0]) + DW'(p2[k][1]) + DW'(p2[k][2])
                - DW'(p2[k][3]) - DW'(p2[k][4]) - DW'(p2[k][5]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_DETS; k++)
      absd[k] = det[k][DW-1] ? DW'(-det[k]) : DW'(det[k]);
  end

  assign entry = {(det[0] == '0),
                  det[3][DW-1] ^ det[0][DW-1],
                  det[2][DW-1] ^ det[0][DW-1],
                  det[1][DW-1] ^ det[0][DW-1],
                  absd[3][MW-1:0], absd[2][MW-1:0], absd[1][MW-1:0], absd[0][MW-1:0]};
endmodule

// ===== sv/c3s_fifo.sv =====
// small queue between front and back
`timescale 1ns / 1ps
module c3s_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = c3s_pkg::QDEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [WIDTH-1:0] wdata,
  output logic full,
  input  logic pop,
  output logic [WIDTH-1:0] rdata,
  output logic avail
);
  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;

  assign full = (count == CNTW'(DEPTH));
  assign avail = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= PW'(wr_ptr + 1'b1);
      if (pop) rd_ptr <= PW'(rd_ptr + 1'b1);
      if (push && !pop) count <= CNTW'(count + 1'b1);
      else if (pop && !push) count <= CNTW'(count - 1'b1);
    end
  end
endmodule

// ===== sv/c3s_back.sv =====
// back end: pipelined restoring division, rounding and saturation
`timescale 1ns / 1ps
module c3s_back #(
  parameter int COEF_WIDTH   = c3s_pkg::CW_DEF,
  parameter int RESULT_WIDTH = c3s_pkg::RW_DEF,
  parameter int RESULT_FRAC  = c3s_pkg::RF_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic avail,
  output logic pop,
  input  logic [4*3*COEF_WIDTH+3:0] entry,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [RESULT_WIDTH-1:0] x [3],
  output logic singular
);
  localparam int MW = 3 * COEF_WIDTH;
  localparam int RW = RESULT_WIDTH;
  localparam int QW = RW + 2;
  localparam int HW = MW + RESULT_FRAC + 1;
  localparam int NW = HW + QW;
  localparam logic [QW:0] LIM_NEG = {{(QW+1-RW){1'b0}}, 1'b1, {(RW-1){1'b0}}};
  localparam logic [QW:0] LIM_POS = LIM_NEG - 1'b1;

  logic adv;
  logic          vv   [QW+1];
  logic          sing [QW+1];
  logic [MW-1:0] dd   [QW+1];
  logic          ovf  [QW+1][3];
  logic          neg  [QW+1][3];
  logic [QW-1:0] q    [QW+1][3];
  logic [MW-1:0] rem  [QW][3];
  logic [QW-1:0] low  [QW][3];

  logic [MW-1:0] e_n [3];
  logic [NW-1:0] nf [3];
  logic [MW:0]   r_step [QW+1][3];
  logic          ge [QW+1][3];
  logic [QW:0]   rounded [3];
  logic [QW:0]   mag [3];
  logic [QW:0]   res [3];

  assign adv = !out_valid || !out_stall;
  assign pop = avail && adv;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      e_n[l] = entry[MW*(l+1) +: MW];
      nf[l]  = NW'(e_n[l]) << (RESULT_FRAC + 1);
    end
  end

  // one quotient bit per stage
  always_comb begin
    for (int s = 0; s <= QW; s++)
      for (int l = 0; l < 3; l++) begin
        r_step[s][l] = '0;
        ge[s][l] = 1'b0;
      end
    for (int s = 1; s <= QW; s++)
      for (int l = 0; l < 3; l++) begin
        r_step[s][l] = {rem[s-1][l], low[s-1][l][QW-1]};
        ge[s][l] = r_step[s][l] >= {1'b0, dd[s-1]};
      end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= QW; s++) vv[s] <= 1'b0;
    end else if (adv) begin
      vv[0] <= pop;
      for (int s = 1; s <= QW; s++) vv[s] <= vv[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sing[0] <= entry[4*MW+3];
      dd[0]   <= entry[MW-1:0];
      for (int l = 0; l < 3; l++) begin
        neg[0][l] <= entry[4*MW+l];
        // quotient too wide for the result range already
        ovf[0][l] <= nf[l][NW-1:QW] >= HW'(entry[MW-1:0]);
        rem[0][l] <= nf[l][QW+MW-1:QW];
        low[0][l] <= nf[l][QW-1:0];
        q[0][l]   <= '0;
      end
      for (int s = 1; s <= QW; s++) begin
        sing[s] <= sing[s-1];
        dd[s]   <= dd[s-1];
        for (int l = 0; l < 3; l++) begin
          neg[s][l] <= neg[s-1][l];
          ovf[s][l] <= ovf[s-1][l];
          q[s][l]   <= {q[s-1][l][QW-2:0], ge[s][l]};
          if (s < QW) begin
            rem[s][l] <= ge[s][l] ? MW'(r_step[s][l] - {1'b0, dd[s-1]})
                                  : r_step[s][l][MW-1:0];
            low[s][l] <= {low[s-1][l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // extra quotient bit gives round half away from zero on the magnitude
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rounded[l] = ({1'b0, q[QW][l]} + 1'b1) >> 1;
      if (ovf[QW][l] || rounded[l] > (neg[QW][l] ? LIM_NEG : LIM_POS))
        mag[l] = neg[QW][l] ? LIM_NEG : LIM_POS;
      else
        mag[l] = rounded[l];
      res[l] = neg[QW][l] ? (QW+1)'(-mag[l]) : mag[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vv[QW];
  end

  always_ff @(posedge clk) begin
    if (adv && vv[QW]) begin
      singular <= sing[QW];
      for (int l = 0; l < 3; l++)
        x[l] <= sing[QW] ? '0 : res[l][RW-1:0];
    end
  end
endmodule

// ===== sv/cramer_3x3_solver_unit.sv =====
// top level of the 3x3 linear system solver
//
// input channel: in_valid/in_stall with nine matrix coefficients and three
//   right-hand side values, signed fixed point of COEF_WIDTH bits
// output channel: out_valid/out_stall with x_first, x_second, x_third
//   (signed, RESULT_FRAC fraction bits, rounded and saturated) and singular
// an item is taken at a clock edge with valid high and stall low
// throughput: one item per cycle while out_stall stays low; the determinant
//   front end and the division back end are both fully pipelined
// path: from accept to out_valid an item passes the determinant pipeline,
//   the queue, the divider of RESULT_WIDTH + 2 stages, the output register
// a singular matrix gives singular high and all three unknowns zero
// a four-item queue sits between the determinant and division halves
// when out_stall is held the back end freezes, the queue fills and then
//   in_stall rises; nothing is lost or repeated
// rst is synchronous; it empties every pipeline stage and the queue
`timescale 1ns / 1ps
module cramer_3x3_solver_unit #(
  parameter int COEF_WIDTH   = c3s_pkg::CW_DEF,
  parameter int RESULT_WIDTH = c3s_pkg::RW_DEF,
  parameter int RESULT_FRAC  = c3s_pkg::RF_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [COEF_WIDTH-1:0] a_r0_c0,
  input  logic signed [COEF_WIDTH-1:0] a_r0_c1,
  input  logic signed [COEF_WIDTH-1:0] a_r0_c2,
  input  logic signed [COEF_WIDTH-1:0] a_r1_c0,
  input  logic signed [COEF_WIDTH-1:0] a_r1_c1,
  input  logic signed [COEF_WIDTH-1:0] a_r1_c2,
  input  logic signed [COEF_WIDTH-1:0] a_r2_c0,
  input  logic signed [COEF_WIDTH-1:0] a_r2_c1,
  input  logic signed [COEF_WIDTH-1:0] a_r2_c2,
  input  logic signed [COEF_WIDTH-1:0] b_r0,
  input  logic signed [COEF_WIDTH-1:0] b_r1,
  input  logic signed [COEF_WIDTH-1:0] b_r2,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [RESULT_WIDTH-1:0] x_first,
  output logic signed [RESULT_WIDTH-1:0] x_second,
  output logic signed [RESULT_WIDTH-1:0] x_third,
  output logic singular
);
  import c3s_pkg::*;
  localparam int EW = 4 * 3 * COEF_WIDTH + 4;

  logic signed [COEF_WIDTH-1:0] a [3][3];
  logic signed [COEF_WIDTH-1:0] b [3];
  logic signed [RESULT_WIDTH-1:0] x [3];
  logic push, full, pop, avail;
  logic [EW-1:0] wdata, rdata;

  assign a[0][0] = a_r0_c0;
  assign a[0][1] = a_r0_c1;
  assign a[0][2] = a_r0_c2;
  assign a[1][0] = a_r1_c0;
  assign a[1][1] = a_r1_c1;
  assign a[1][2] = a_r1_c2;
  assign a[2][0] = a_r2_c0;
  assign a[2][1] = a_r2_c1;
  assign a[2][2] = a_r2_c2;
  assign b[0] = b_r0;
  assign b[1] = b_r1;
  assign b[2] = b_r2;

  c3s_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .a(a), .b(b), .push(push), .full(full), .entry(wdata)
  );

  c3s_fifo #(.WIDTH(EW), .DEPTH(QDEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(wdata), .full(full),
    .pop(pop), .rdata(rdata), .avail(avail)
  );

  c3s_back #(
    .COEF_WIDTH(COEF_WIDTH), .RESULT_WIDTH(RESULT_WIDTH), .RESULT_FRAC(RESULT_FRAC)
  ) u_back (
    .clk(clk), .rst(rst), .avail(avail), .pop(pop), .entry(rdata),
    .out_valid(out_valid), .out_stall(out_stall), .x(x), .singular(singular)
  );

  assign x_first  = x[0];
  assign x_second = x[1];
  assign x_third  = x[2];
endmodule

// ===== sv/c3s_checker.sv =====
// port-level checks on the solver output channel
`timescale 1ns / 1ps
`include "cramer_3x3_solver_unit_assert.svh"
module c3s_checker #(
  parameter int RESULT_WIDTH = c3s_pkg::RW_DEF
) (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic signed [RESULT_WIDTH-1:0] x_first,
  input logic signed [RESULT_WIDTH-1:0] x_second,
  input logic signed [RESULT_WIDTH-1:0] x_third,
  input logic singular
);
  `C3S_ASSERT_NOW(a_sing_zero, clk, rst, out_valid && singular, x_first == '0 && x_second == '0 && x_third == '0)
  `C3S_ASSERT_NEXT(a_rst_idle, clk, 1'b0, rst, !out_valid)
  `C3S_ASSERT_NEXT(a_hold_valid, clk, rst, out_valid && out_stall, out_valid)
  `C3S_ASSERT_NEXT(a_hold_data, clk, rst, out_valid && out_stall, $stable(x_first) && $stable(x_second) && $stable(x_third) && $stable(singular))
endmodule

bind cramer_3x3_solver_unit c3s_checker #(.RESULT_WIDTH(RESULT_WIDTH)) u_c3s_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .x_first(x_first), .x_second(x_second), .x_third(x_third), .singular(singular)
);
